### design/bsud_pkg.sv
// Package of the up/down bubble sorter: shared constants, the controller
// state type and the command and status structs between controller and datapath.
// Has no dependencies of its own.
package bsud_pkg;

  // Default capacity of the element store.
  localparam int unsigned MaxElementsDef = 64;

  // Width of one element.
  localparam int unsigned ValueW = 8;

  // Controller states.
  typedef enum logic [3:0] {
    StCollect,
    StSortInit,
    StPassStart,
    StPassFirst,
    StPassStep,
    StPassEnd,
    StOutRead,
    StOutLoad,
    StOutHold
  } bsud_state_e;

  // Read address selection of the element store.
  typedef enum logic [1:0] {
    RdZero,
    RdNext,
    RdOut
  } bsud_rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         store_in;    // an input item is accepted this cycle
    logic         sort_init;   // set up the pass limit and output index
    logic         pass_start;  // clear pass index and swap flag
    logic         first_load;  // take element 0 into the carry register
    logic         step;        // compare carry with next element, write back
    logic         pass_end;    // write carry to the end of the pass
    logic         out_load;    // load the output register from the store
    logic         out_next;    // advance the output index
    logic         run_done;    // empty the store for the next run
    bsud_rd_sel_e rd_sel;
  } bsud_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_ge2;   // at least two elements stored
    logic at_limit;    // pass index has reached the pass limit
    logic swapped;     // the current pass swapped a pair
    logic limit_one;   // the pass just finished was one compare long
    logic out_last;    // output index points at the final element
    logic out_taken;   // the output item is taken this cycle
  } bsud_stat_t;

endpackage

### design/bsud_datapath.sv
// Datapath of the up/down bubble sorter: element store, counters, carry
// register, comparator, output register and the direction register.
// Depends on bsud_pkg.
module bsud_datapath
  import bsud_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsud_cmd_t         cmd_i,
  output bsud_stat_t        stat_o,
  input  logic [ValueW-1:0] in_value_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_data_i,
  output logic [ValueW-1:0] out_value_o,
  output logic              out_last_o,
  output logic              out_overflow_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  localparam int unsigned AddrW = $clog2(MaxElements);
  localparam int unsigned CntW  = $clog2(MaxElements + 1);

  logic [ValueW-1:0] mem_q [MaxElements];
  logic [ValueW-1:0] rdata_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              dropped_q, dropped_d;
  logic              descending_q;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  limit_q, limit_d;
  logic [AddrW-1:0]  k_q, k_d;
  logic [ValueW-1:0] carry_q, carry_d;
  logic              swapped_q, swapped_d;
  logic [ValueW-1:0] out_value_q;
  logic              out_last_q, out_overflow_q, out_valid_q, out_valid_d;

  logic              full;
  logic              out_of_order;
  logic [ValueW-1:0] low_value;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [ValueW-1:0] wr_data;
  logic [AddrW-1:0]  rd_addr;
  logic              out_last;

  assign full = (count_q == CntW'(MaxElements));

  // Adjacent compare: carry holds the left element, the read data the right one.
  always_comb begin
    if (descending_q) begin
      out_of_order = $signed(carry_q) < $signed(rdata_q);
    end else begin
      out_of_order = $signed(carry_q) > $signed(rdata_q);
    end
    low_value = out_of_order ? rdata_q : carry_q;
  end

  assign out_last = (CntW'(k_q) == (count_q - CntW'(1)));

  // Write port of the element store.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = limit_q;
    wr_data = carry_q;
    if (cmd_i.store_in && !full) begin
      wr_en   = 1'b1;
      wr_addr = count_q[AddrW-1:0];
      wr_data = in_value_i;
    end else if (cmd_i.step) begin
      wr_en   = 1'b1;
      wr_addr = idx_q - AddrW'(1);
      wr_data = low_value;
    end else if (cmd_i.pass_end) begin
      wr_en   = 1'b1;
    end
  end

  // Read address of the element store.
  always_comb begin
    case (cmd_i.rd_sel)
      RdZero:  rd_addr = '0;
      RdNext:  rd_addr = idx_q + AddrW'(1);
      RdOut:   rd_addr = k_q;
      default: rd_addr = '0;
    endcase
  end

  // Element store with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Next values of counters and sorting registers.
  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    limit_d     = limit_q;
    k_d         = k_q;
    carry_d     = carry_q;
    swapped_d   = swapped_q;
    out_valid_d = out_valid_q;
    if (cmd_i.store_in) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.sort_init) begin
      limit_d = AddrW'(count_q - CntW'(1));
      k_d     = '0;
    end
    if (cmd_i.pass_start) begin
      idx_d     = '0;
      swapped_d = 1'b0;
    end
    if (cmd_i.first_load) begin
      carry_d = rdata_q;
      idx_d   = idx_q + AddrW'(1);
    end
    if (cmd_i.step) begin
      carry_d   = out_of_order ? carry_q : rdata_q;
      swapped_d = swapped_q | out_of_order;
      idx_d     = idx_q + AddrW'(1);
    end
    if (cmd_i.pass_end) begin
      limit_d = limit_q - AddrW'(1);
    end
    if (cmd_i.out_next) begin
      k_d = k_q + AddrW'(1);
    end
    if (cmd_i.run_done) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      dropped_q    <= 1'b0;
      descending_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        descending_q <= cfg_data_i;
      end
    end
  end

  // Working registers of the sort.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    limit_q   <= limit_d;
    k_q       <= k_d;
    carry_q   <= carry_d;
    swapped_q <= swapped_d;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q    <= rdata_q;
      out_last_q     <= out_last;
      out_overflow_q <= out_last & dropped_q;
    end
  end

  assign out_value_o    = out_value_q;
  assign out_last_o     = out_last_q;
  assign out_overflow_o = out_overflow_q;
  assign out_valid_o    = out_valid_q;

  always_comb begin
    stat_o.count_ge2 = (count_q >= CntW'(2));
    stat_o.at_limit  = (idx_q == limit_q);
    stat_o.swapped   = swapped_q;
    stat_o.limit_one = (limit_q == AddrW'(1));
    stat_o.out_last  = out_last;
    stat_o.out_taken = out_valid_q & out_ready_i;
  end

endmodule

### design/bsud_ctrl.sv
// Controller of the up/down bubble sorter: sequences collection, sort passes
// and the output burst by commands to the datapath.
// Depends on bsud_pkg.
module bsud_ctrl
  import bsud_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  bsud_stat_t stat_i,
  output bsud_cmd_t  cmd_o
);

  bsud_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCollect;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = RdZero;
    case (state_q)
      StCollect: begin
        in_ready_o     = 1'b1;
        cmd_o.store_in = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = StSortInit;
        end
      end
      StSortInit: begin
        cmd_o.sort_init = 1'b1;
        state_d = stat_i.count_ge2 ? StPassStart : StOutRead;
      end
      StPassStart: begin
        cmd_o.pass_start = 1'b1;
        cmd_o.rd_sel     = RdZero;
        state_d          = StPassFirst;
      end
      StPassFirst: begin
        cmd_o.first_load = 1'b1;
        cmd_o.rd_sel     = RdNext;
        state_d          = StPassStep;
      end
      StPassStep: begin
        cmd_o.step   = 1'b1;
        cmd_o.rd_sel = RdNext;
        if (stat_i.at_limit) begin
          state_d = StPassEnd;
        end
      end
      StPassEnd: begin
        // Stop after a pass without a swap or after the shortest pass.
        cmd_o.pass_end = 1'b1;
        if (!stat_i.swapped || stat_i.limit_one) begin
          state_d = StOutRead;
        end else begin
          state_d = StPassStart;
        end
      end
      StOutRead: begin
        cmd_o.rd_sel = RdOut;
        state_d      = StOutLoad;
      end
      StOutLoad: begin
        cmd_o.out_load = 1'b1;
        state_d        = StOutHold;
      end
      StOutHold: begin
        if (stat_i.out_taken) begin
          if (stat_i.out_last) begin
            cmd_o.run_done = 1'b1;
            state_d        = StCollect;
          end else begin
            cmd_o.out_next = 1'b1;
            state_d        = StOutRead;
          end
        end
      end
      default: begin
        state_d = StCollect;
      end
    endcase
  end

endmodule

### design/bubble_sorter_up_down.sv
// Up/down bubble sorter. An item is taken each cycle while a run is collected.
// After the closing item, the store is sorted in passes, at most N - 1 passes
// for N stored items; the sorted burst then leaves one item at a time, the next
// read from the store only after the sink has taken the last one.
// Reset empties the store count, clears the dropped flag and selects ascending
// order; store contents are not cleared.
module bubble_sorter_up_down
  import bsud_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ValueW-1:0] s_axis_tdata,   // [7:0] value
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ValueW-1:0] m_axis_tdata,   // [7:0] sorted_value
  output logic              m_axis_tlast,
  output logic              m_axis_tuser,   // [0] overflow
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i      // [0] descending
);

  bsud_cmd_t  cmd;
  bsud_stat_t stat;

  // The direction register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  bsud_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bsud_datapath #(
    .MaxElements (MaxElements)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_value_i     (s_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_value_o    (m_axis_tdata),
    .out_last_o     (m_axis_tlast),
    .out_overflow_o (m_axis_tuser),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready)
  );

endmodule
